FILE: hw/rtl/sdw_pkg.sv
// ----------------------------------------------------------------------------
// sdw_pkg
// Shared types, constants and the segment code table of the digit writer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdw_pkg;

   localparam int DigitCount = 6;
   localparam int SegBytes   = 20;
   localparam int SegStride  = 5;
   localparam int NibCount   = 4;
   localparam int ValueWidth = 31;
   localparam int OffWidth   = 5;
   localparam int ProdWidth  = 63;
   localparam int QuotWidth  = 28;
   localparam int RecipShift = 35;

   localparam logic [31:0] Recip     = 32'hCCCC_CCCD;
   localparam logic [7:0]  AsciiZero = 8'd48;
   localparam logic [7:0]  AsciiNine = 8'd57;

   typedef enum logic {
      CMD_CHAR   = 1'b0,
      CMD_NUMBER = 1'b1
   } cmd_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic digit;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_number;
      logic req_pos_ok;
      logic rsp_free;
      logic nib_last;
      logic steps_done;
      logic is_number;
   } ctrl_status_type;

   function automatic logic [15:0] seg_code(input logic [3:0] digit);
      logic [15:0] code;
      case (digit)
         4'd0:    code = 16'h1551;
         4'd1:    code = 16'h0110;
         4'd2:    code = 16'h1E11;
         4'd3:    code = 16'h1B11;
         4'd4:    code = 16'h0B50;
         4'd5:    code = 16'h1B41;
         4'd6:    code = 16'h1F41;
         4'd7:    code = 16'h0111;
         4'd8:    code = 16'h1F51;
         4'd9:    code = 16'h1B51;
         default: code = 16'h0000;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sdw_if.sv
// ----------------------------------------------------------------------------
// sdw_if
// Request and response channels of the digit writer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdw_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  ch;
   logic [2:0]  pos;
   logic [30:0] value;

   modport source (output valid, output cmd, output ch, output pos, output value,
                   input ready);
   modport sink   (input valid, input cmd, input ch, input pos, input value,
                   output ready);
endinterface

interface sdw_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] reg_offset;
   logic [7:0] reg_data;
   logic       last;

   modport source (output valid, output reg_offset, output reg_data, output last,
                   input ready);
   modport sink   (input valid, input reg_offset, input reg_data, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sdw_ctrl.sv
// ----------------------------------------------------------------------------
// sdw_ctrl
// Sequencer: accepts a request and steps the datapath through digits and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module sdw_ctrl
   import sdw_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_DIGIT = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.req_number) begin
                  state_in = ST_MUL;
               end else if (status.req_pos_ok) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            cmd.digit = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (status.nib_last) begin
                  state_in = (status.is_number && !status.steps_done) ? ST_MUL : ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sdw_datapath.sv
// ----------------------------------------------------------------------------
// sdw_datapath
// Segment memory, digit extraction by reciprocal multiply and nibble merge.
// ----------------------------------------------------------------------------
`default_nettype none

module sdw_datapath
   import sdw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_cmd,
   input  wire logic [7:0]            req_ch,
   input  wire logic [2:0]            req_pos,
   input  wire logic [ValueWidth-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [OffWidth-1:0]        rsp_reg_offset,
   output logic [7:0]                 rsp_reg_data,
   output logic                       rsp_last,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_status_type            status
);

   logic [7:0]            mem_ff [SegBytes];
   logic [7:0]            rd_ff;
   logic [ValueWidth-1:0] num_ff, num_in;
   logic [ProdWidth-1:0]  prod_ff;
   logic [15:0]           code_ff, code_in;
   logic [2:0]            pos_ff, pos_in;
   logic [1:0]            nib_ff, nib_in;
   logic [2:0]            step_ff, step_in;
   logic                  zero_ff, zero_in;
   logic                  number_ff, number_in;
   logic                  rsp_valid_ff;
   logic [OffWidth-1:0]   rsp_off_ff;
   logic [7:0]            rsp_data_ff;
   logic                  rsp_last_ff;

   logic [QuotWidth-1:0]  quot;
   logic [ValueWidth-1:0] quot_x10;
   logic [3:0]            digit_d;
   logic [OffWidth-1:0]   off_d;
   logic [OffWidth-1:0]   off_next;
   logic [7:0]            merged_d;
   logic                  last_d;

   assign quot     = prod_ff[RecipShift +: QuotWidth];
   assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign digit_d  = 4'(num_ff - quot_x10);

   assign off_d    = OffWidth'(pos_ff[2:1]) + OffWidth'(nib_ff) * OffWidth'(SegStride);
   assign off_next = OffWidth'(pos_in[2:1]) + OffWidth'(nib_in) * OffWidth'(SegStride);
   assign merged_d = pos_ff[0] ? {code_ff[3:0], rd_ff[3:0]}
                               : {rd_ff[7:4], code_ff[3:0]};
   assign last_d   = (nib_ff == 2'(NibCount - 1)) &&
                     (!number_ff || step_ff == 3'(DigitCount));

   always_comb begin
      num_in    = num_ff;
      code_in   = code_ff;
      pos_in    = pos_ff;
      nib_in    = nib_ff;
      step_in   = step_ff;
      zero_in   = zero_ff;
      number_in = number_ff;
      if (cmd.load) begin
         number_in = (req_cmd == CMD_NUMBER);
         num_in    = req_value;
         zero_in   = (req_value == '0);
         pos_in    = req_pos;
         step_in   = '0;
         nib_in    = '0;
         code_in   = (req_ch >= AsciiZero && req_ch <= AsciiNine) ?
                     seg_code(4'(req_ch - AsciiZero)) : '0;
      end
      if (cmd.digit) begin
         code_in = (step_ff == '0 || num_ff != '0) ? seg_code(digit_d) : '0;
         num_in  = ValueWidth'(quot);
         if (step_ff == '0) begin
            pos_in = 3'(DigitCount - 1);
         end else if (zero_ff) begin
            pos_in = step_ff - 3'd1;
         end else begin
            pos_in = 3'(DigitCount - 1) - step_ff;
         end
         nib_in  = '0;
         step_in = step_ff + 3'd1;
      end
      if (cmd.emit) begin
         code_in = {4'b0000, code_ff[15:4]};
         nib_in  = nib_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      code_ff   <= code_in;
      pos_ff    <= pos_in;
      nib_ff    <= nib_in;
      step_ff   <= step_in;
      zero_ff   <= zero_in;
      number_ff <= number_in;
      rd_ff     <= mem_ff[off_next];
      if (cmd.mul) begin
         prod_ff <= ProdWidth'(num_ff) * ProdWidth'(Recip);
      end
      if (cmd.emit) begin
         rsp_off_ff  <= off_d;
         rsp_data_ff <= merged_d;
         rsp_last_ff <= last_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SegBytes; k++) begin
            mem_ff[k] <= '0;
         end
      end else if (cmd.emit) begin
         mem_ff[off_d] <= merged_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_offset = rsp_off_ff;
   assign rsp_reg_data   = rsp_data_ff;
   assign rsp_last       = rsp_last_ff;

   assign status.req_number = (req_cmd == CMD_NUMBER);
   assign status.req_pos_ok = (req_pos < 3'(DigitCount));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.nib_last   = (nib_ff == 2'(NibCount - 1));
   assign status.steps_done = (step_ff == 3'(DigitCount));
   assign status.is_number  = number_ff;

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("write issued while response register busy");

   a_mem_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (mem_ff[rsp_off_ff] == rsp_data_ff))
      else $error("segment memory disagrees with emitted byte");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (off_d < OffWidth'(SegBytes)))
      else $error("segment offset out of range");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.digit |-> (digit_d < 4'd10))
      else $error("extracted digit out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/segment_display_digit_writer_core.sv
// ----------------------------------------------------------------------------
// segment_display_digit_writer_core
// Six-digit segment display writer with a 20-byte segment memory.
// ----------------------------------------------------------------------------
// A character request with position 0..5 is accepted and then gives four
// register writes, one per cycle while the response side keeps up;
// positions 6 and 7 are accepted and give no response. A number request
// is accepted, then for each of the six digit positions runs a multiply
// step, a digit step and four writes. The multiply-by-reciprocal divide
// by ten and the single segment memory write port shape this sequence.
// Each write is a read-modify-write of one segment byte, reported as one
// response; the final response of a request has last set.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_display_digit_writer_core
   import sdw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sdw_req_if.sink   req_bus,
   sdw_rsp_if.source rsp_bus
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;

   sdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_bus.cmd),
      .req_ch         (req_bus.ch),
      .req_pos        (req_bus.pos),
      .req_value      (req_bus.value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_reg_offset (rsp_bus.reg_offset),
      .rsp_reg_data   (rsp_bus.reg_data),
      .rsp_last       (rsp_bus.last),
      .cmd            (cmd),
      .status         (status)
   );

   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire

FILE: tb/sv/segment_display_digit_writer_core_test.sv
// ----------------------------------------------------------------------------
// segment_display_digit_writer_core_test
// Self-checking bench for the digit writer. A short table of directed
// requests (blank and out-of-range characters, every digit, zero, long and
// maximal numbers) runs first, then about 500 random requests. A local model
// of the 20-byte segment memory predicts every register write. Requests go in
// bursts with random gaps, and the response side stalls on its own pattern.
// ----------------------------------------------------------------------------

module segment_display_digit_writer_core_test
   import sdw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomRequests = 500;
   localparam int HangLimit      = 4000;
   localparam int SettleCycles   = 60;

   localparam logic [15:0] GLYPHS [10] = '{
      16'h1551, 16'h0110, 16'h1E11, 16'h1B11, 16'h0B50,
      16'h1B41, 16'h1F41, 16'h0111, 16'h1F51, 16'h1B51
   };

   typedef struct packed {
      cmd_type         cmd;
      logic [7:0]      ch;
      logic [2:0]      pos;
      logic [30:0]     value;
      logic            typed;
      logic [2:0]      count;
      logic [0:3][4:0] offs;
      logic [0:3][7:0] data;
   } stim_row_type;

   typedef struct packed {
      logic [4:0] offset;
      logic [7:0] data;
      logic       last;
   } seg_write_type;

   logic clock;
   logic reset;
   int   req_tag;
   int   fail_count = 0;
   int   idle_cycles = 0;
   int   rsp_mode = 0;
   int   rsp_mode_left = 0;

   logic [7:0]    seg_mem [SegBytes];
   seg_write_type predicted_writes[$];
   seg_write_type pending_writes[$];
   stim_row_type  dir_table[$];

   sdw_req_if req_bus ();
   sdw_rsp_if rsp_bus ();

   segment_display_digit_writer_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      foreach (seg_mem[i]) seg_mem[i] = 8'h00;
   end

   // ---- segment memory model ----

   function automatic logic [15:0] glyph_for(input logic [7:0] ch);
      if (ch >= AsciiZero && ch <= AsciiNine) begin
         return GLYPHS[ch - AsciiZero];
      end
      return 16'h0000;
   endfunction

   task automatic write_glyph(input logic [7:0] ch, input int pos);
      logic [15:0] code;
      logic [4:0]  off;
      logic [7:0]  b;
      if (pos >= DigitCount) return;
      code = glyph_for(ch);
      for (int i = 0; i < NibCount; i++) begin
         off = 5'(pos / 2 + i * SegStride);
         b = seg_mem[off];
         if (pos % 2 == 0) begin
            b = {b[7:4], code[3:0]};
         end else begin
            b = {code[3:0], b[3:0]};
         end
         code = code >> 4;
         seg_mem[off] = b;
         predicted_writes.push_back('{offset: off, data: b, last: 1'b0});
      end
   endtask

   task automatic predict_request(input cmd_type cmd, input logic [7:0] ch,
                                  input logic [2:0] pos, input logic [30:0] value);
      logic [30:0] rest;
      int          p;
      predicted_writes.delete();
      rest = value;
      p = DigitCount - 1;
      if (cmd == CMD_CHAR) begin
         write_glyph(ch, int'(pos));
      end else if (rest == 0) begin
         write_glyph(AsciiZero, DigitCount - 1);
         for (int q = 0; q < DigitCount - 1; q++) write_glyph(8'h00, q);
      end else begin
         while (rest != 0 && p >= 0) begin
            write_glyph(AsciiZero + 8'(rest % 10), p);
            rest = rest / 10;
            p--;
         end
         while (p >= 0) begin
            write_glyph(8'h00, p);
            p--;
         end
      end
   endtask

   // ---- request monitor and response checker ----

   always @(posedge clock) begin
      seg_write_type w;
      stim_row_type  row;
      int            n;
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_request(cmd_type'(req_bus.cmd), req_bus.ch, req_bus.pos, req_bus.value);
         if (req_tag >= 0 && dir_table[req_tag].typed) begin
            row = dir_table[req_tag];
            for (int i = 0; i < int'(row.count); i++) begin
               w.offset = row.offs[i];
               w.data   = row.data[i];
               w.last   = (i == int'(row.count) - 1);
               pending_writes.push_back(w);
            end
         end else begin
            n = predicted_writes.size();
            for (int i = 0; i < n; i++) begin
               w = predicted_writes[i];
               w.last = (i == n - 1);
               pending_writes.push_back(w);
            end
         end
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write offset %0d data 0x%02h last %0b", $time,
                     rsp_bus.reg_offset, rsp_bus.reg_data, rsp_bus.last);
            fail_count++;
         end else begin
            w = pending_writes.pop_front();
            if (rsp_bus.reg_offset !== w.offset) begin
               $display("%0t: reg_offset expected %0d actual %0d", $time, w.offset,
                        rsp_bus.reg_offset);
               fail_count++;
            end
            if (rsp_bus.reg_data !== w.data) begin
               $display("%0t: reg_data at %0d expected 0x%02h actual 0x%02h", $time,
                        w.offset, w.data, rsp_bus.reg_data);
               fail_count++;
            end
            if (rsp_bus.last !== w.last) begin
               $display("%0t: last at %0d expected %0b actual %0b", $time, w.offset,
                        w.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // ---- response stall pattern ----

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_mode_left == 0) begin
            rsp_mode      = $urandom_range(0, 3);
            rsp_mode_left = $urandom_range(16, 96);
         end
         rsp_mode_left--;
         case (rsp_mode)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            end
         endcase
      end
   end

   // ---- hang watchdog ----

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HangLimit) begin
         $display("%0t: no progress for %0d cycles", $time, HangLimit);
         $display("tb: failure");
         $finish;
      end
   end

   // ---- request generation ----

   task automatic add_row(input cmd_type cmd, input logic [7:0] ch, input logic [2:0] pos,
                          input logic [30:0] value, input logic typed,
                          input logic [2:0] count, input logic [0:3][4:0] offs,
                          input logic [0:3][7:0] data);
      stim_row_type row;
      row.cmd   = cmd;
      row.ch    = ch;
      row.pos   = pos;
      row.value = value;
      row.typed = typed;
      row.count = count;
      row.offs  = offs;
      row.data  = data;
      dir_table.push_back(row);
   endtask

   function automatic stim_row_type random_request();
      stim_row_type row;
      logic [30:0]  v;
      row = '0;
      row.ch    = 8'($urandom_range(0, 255));
      row.pos   = 3'($urandom_range(0, 7));
      row.value = 31'($urandom);
      if ($urandom_range(0, 9) < 6) begin
         row.cmd = CMD_CHAR;
         if ($urandom_range(0, 9) < 8) row.ch = AsciiZero + 8'($urandom_range(0, 9));
         if ($urandom_range(0, 9) < 9) row.pos = 3'($urandom_range(0, DigitCount - 1));
      end else begin
         row.cmd = CMD_NUMBER;
         case ($urandom_range(0, 5))
            0: v = 31'($urandom_range(0, 9));
            1: v = 31'($urandom_range(0, 999));
            2: v = 31'($urandom_range(0, 999999));
            3: v = 31'($urandom_range(1000000, 32'h7FFF_FFFF));
            4: v = 31'($urandom);
            default: begin
               v = 31'($urandom_range(1, 9));
               repeat ($urandom_range(0, 8)) v = v * 10;
            end
         endcase
         row.value = v;
      end
      return row;
   endfunction

   task automatic send_request(input stim_row_type row, input int tag);
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= row.cmd;
      req_bus.ch    <= row.ch;
      req_bus.pos   <= row.pos;
      req_bus.value <= row.value;
      req_tag       <= tag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic pace(inout int burst_left);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 2) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_writes.size() != 0);
   endtask

   initial begin
      int burst_left;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= CMD_CHAR;
      req_bus.ch    <= 8'h00;
      req_bus.pos   <= 3'd0;
      req_bus.value <= 31'd0;
      req_tag       <= -1;
      burst_left = $urandom_range(1, 16);

      // known results from cleared memory
      add_row(CMD_CHAR, 8'd48, 3'd0, 31'h7FFF_FFFF, 1'b1, 3'd4,
              {5'd0, 5'd5, 5'd10, 5'd15}, {8'h01, 8'h05, 8'h05, 8'h01});
      add_row(CMD_CHAR, 8'd56, 3'd1, 31'd0, 1'b1, 3'd4,
              {5'd0, 5'd5, 5'd10, 5'd15}, {8'h11, 8'h55, 8'hF5, 8'h11});
      add_row(CMD_CHAR, 8'h41, 3'd5, 31'd12345, 1'b1, 3'd4,
              {5'd2, 5'd7, 5'd12, 5'd17}, '0);
      add_row(CMD_CHAR, 8'd57, 3'd6, 31'h5555_5555, 1'b1, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'hFF, 3'd7, 31'h2AAA_AAAA, 1'b1, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'hFF, 3'd4, 31'd0, 1'b1, 3'd4,
              {5'd2, 5'd7, 5'd12, 5'd17}, '0);
      // just outside the digit range, then the digits 9 and 1 to 7
      add_row(CMD_CHAR, 8'd47, 3'd2, 31'd1, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd58, 3'd3, 31'd2, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd57, 3'd5, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd49, 3'd0, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd50, 3'd1, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd51, 3'd2, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd52, 3'd3, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd53, 3'd4, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd54, 3'd5, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_CHAR, 8'd55, 3'd0, 31'd0, 1'b0, 3'd0, '0, '0);
      // numbers: zero, short, trailing zeros, six digits, overflow, maximum
      add_row(CMD_NUMBER, 8'hFF, 3'd7, 31'd0, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'd53, 3'd2, 31'd1, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'd0, 3'd0, 31'd7, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'd0, 3'd0, 31'd10, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'd0, 3'd0, 31'd100, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'd0, 3'd0, 31'd123456, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'd0, 3'd0, 31'd999999, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'd0, 3'd0, 31'd1000000, 1'b0, 3'd0, '0, '0);
      add_row(CMD_NUMBER, 8'hAA, 3'd5, 31'h7FFF_FFFF, 1'b0, 3'd0, '0, '0);

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (dir_table[i]) begin
         send_request(dir_table[i], i);
         if (i == dir_table.size() - 1) wait_for_drain();
         else pace(burst_left);
      end

      for (int n = 0; n < RandomRequests; n++) begin
         send_request(random_request(), -1);
         if (n == RandomRequests / 2 || n == RandomRequests - 1) wait_for_drain();
         else pace(burst_left);
      end

      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && pending_writes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
